FILE: hdl/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior (the top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tks_pkg.sv
// Shared types and constants of the toroidal kernel splat block.
`timescale 1ns / 1ps

package tks_pkg;

    // Field widths of the input and output words
    localparam int COORD_W  = 16;
    localparam int MAG_W    = COORD_W + 1;   // coordinate minus radius, magnitude
    localparam int KIDX_W   = 8;
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int RCFG_W   = 3;             // kernel_radius register
    localparam int RAD_W    = 4;             // active radius and loop counters
    localparam int IN_W     = 2 * COORD_W + KIDX_W + VAL_W;
    localparam int OUT_W    = VAL_W;

    localparam logic [RCFG_W-1:0] RADIUS_RST = RCFG_W'(2);

    // Operation codes carried in tuser
    typedef enum logic [FUNC_W-1:0] {
        FN_KLOAD = 3'd0,
        FN_FILL  = 3'd1,
        FN_WRITE = 3'd2,
        FN_SPLAT = 3'd3,
        FN_READ  = 3'd4
    } t_func;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;   // latch the accepted word
        logic wrap_start;  // start coordinate reduction
        logic wrap_rad;    // reduce coordinate minus active radius
        logic pos_init;    // load cell position and kernel counters
        logic sweep_step;  // write one grid entry of a sweep
        logic sweep_zero;  // sweep writes zero instead of the item value
        logic kload;       // write one kernel entry
        logic mem_rd;      // read grid cell and kernel entry
        logic grid_wr;     // write item value to current cell
        logic spl_wr;      // write saturated sum to current cell
        logic spl_step;    // advance splat position
        logic res_load;    // load output register
        logic res_read;    // output register takes the read data
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_func in_func;    // operation of the word on the input
        logic  wrap_done;
        logic  sweep_last;
        logic  spl_last;
    } t_status;

endpackage

FILE: hdl/tks_wrap.sv
// Reduction of a signed coordinate modulo a constant grid size by reciprocal multiplication.
`timescale 1ns / 1ps

module tks_wrap import tks_pkg::*; #(
    parameter int MODULUS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_W-1:0]     i_operand,   // signed
    output logic                 o_done,
    output logic [((MODULUS > 1) ? $clog2(MODULUS) : 1)-1:0] o_result
);

    localparam int OUT_BITS = (MODULUS > 1) ? $clog2(MODULUS) : 1;
    localparam int REM_W    = $clog2(MODULUS + 1);
    localparam int SH       = 24;             // reciprocal precision, above the magnitude width
    localparam int PROD_W   = MAG_W + SH;
    localparam int RECIP    = (1 << SH) / MODULUS;
    localparam logic [1:0] STEPS = 2'd3;

    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    logic [MAG_W-1:0] r_quo;   // quotient estimate, low by at most one
    logic [REM_W:0]   r_est;   // remainder estimate, below twice the modulus
    logic [REM_W-1:0] r_rem;
    logic [1:0]       r_cnt;

    logic [REM_W-1:0] fixed;

    // Step counter: multiply, multiply-subtract, correct
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_operand[MAG_W-1];
            r_mag <= i_operand[MAG_W-1] ? (~i_operand + MAG_W'(1)) : i_operand;
        end
        // truncated reciprocal: the estimate misses the quotient by at most one
        if (r_cnt == 2'd3) begin
            r_quo <= MAG_W'((PROD_W'(r_mag) * PROD_W'(RECIP)) >> SH);
        end
        if (r_cnt == 2'd2) begin
            r_est <= (REM_W+1)'(r_mag - r_quo * MAG_W'(MODULUS));
        end
        // one subtract brings the estimate below the modulus
        if (r_cnt == 2'd1) begin
            r_rem <= (r_est >= (REM_W+1)'(MODULUS)) ? REM_W'(r_est - (REM_W+1)'(MODULUS))
                                                    : REM_W'(r_est);
        end
    end

    // Negative operand: size minus remainder, exact multiples give zero
    always_comb begin
        fixed = (r_neg && (r_rem != '0)) ? (REM_W'(MODULUS) - r_rem) : r_rem;
    end

    assign o_done   = (r_cnt == '0);
    assign o_result = OUT_BITS'(fixed);

endmodule

FILE: hdl/tks_dpath.sv
// Datapath: item registers, grid and kernel memories, splat counters, output register.
`timescale 1ns / 1ps

module tks_dpath import tks_pkg::*; #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int MAX_RADIUS  = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_cfg_we,
    input  logic [RCFG_W-1:0]   i_cfg_wdata,
    input  logic [IN_W-1:0]     i_s_axis_tdata,
    input  logic [FUNC_W-1:0]   i_s_axis_tuser,
    output logic [OUT_W-1:0]    o_m_axis_tdata
);

    localparam int GDEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int KSIDE  = 2 * MAX_RADIUS + 1;
    localparam int KDEPTH = KSIDE * KSIDE;
    localparam int GA_W   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int KA_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int XW     = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
    localparam int YW     = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    // Latched item and configuration
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [KIDX_W-1:0]         r_kidx;
    logic [VAL_W-1:0]          r_value;
    logic [RCFG_W-1:0]         r_radius;

    // Sweep, splat position and counters
    logic [GA_W-1:0]  r_sweep;
    logic [XW-1:0]    r_cx;
    logic [YW-1:0]    r_cy;
    logic [RAD_W-1:0] r_ci;
    logic [RAD_W-1:0] r_cj;

    // Memories and their read registers
    logic [VAL_W-1:0] r_grid [GDEPTH];
    logic [VAL_W-1:0] r_kern [KDEPTH];
    logic [VAL_W-1:0] r_grd;
    logic [VAL_W-1:0] r_krd;
    logic [OUT_W-1:0] r_out;

    logic [RAD_W-1:0] rad;
    logic [RAD_W-1:0] span;
    logic [MAG_W-1:0] op_x;
    logic [MAG_W-1:0] op_y;
    logic             done_x;
    logic             done_y;
    logic [XW-1:0]    wx;
    logic [YW-1:0]    wy;
    logic [GA_W-1:0]  addr_cur;
    logic [GA_W-1:0]  gaddr;
    logic             gwe;
    logic [VAL_W-1:0] gwdata;
    logic [KA_W-1:0]  ki;
    logic [KA_W-1:0]  kj;
    logic [KA_W-1:0]  kaddr;
    logic [VAL_W:0]   sum;
    logic [VAL_W-1:0] sat;

    // Active radius, clamped to the kernel size
    always_comb begin
        rad  = (RAD_W'(r_radius) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                       : RAD_W'(r_radius);
        span = rad + rad;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
        end else if (i_cfg_we) begin
            r_radius <= i_cfg_wdata;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x     <= i_s_axis_tdata[COORD_W-1:0];
            r_y     <= i_s_axis_tdata[2*COORD_W-1:COORD_W];
            r_kidx  <= i_s_axis_tdata[2*COORD_W+KIDX_W-1:2*COORD_W];
            r_value <= i_s_axis_tdata[IN_W-1:2*COORD_W+KIDX_W];
        end
    end

    // Coordinate reduction, x and y side by side
    always_comb begin
        op_x = MAG_W'(r_x);
        op_y = MAG_W'(r_y);
        if (i_cmd.wrap_rad) begin
            op_x = MAG_W'(r_x) - MAG_W'(rad);
            op_y = MAG_W'(r_y) - MAG_W'(rad);
        end
    end

    tks_wrap #(.MODULUS(GRID_WIDTH)) u_wrap_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.wrap_start),
        .i_operand (op_x),
        .o_done    (done_x),
        .o_result  (wx)
    );

    tks_wrap #(.MODULUS(GRID_HEIGHT)) u_wrap_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.wrap_start),
        .i_operand (op_y),
        .o_done    (done_y),
        .o_result  (wy)
    );

    // Sweep counter for fill and the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_step) begin
            r_sweep <= (r_sweep == GA_W'(GDEPTH - 1)) ? '0 : r_sweep + GA_W'(1);
        end
    end

    // Splat walk: y inner, x outer, both wrapping around the torus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ci <= '0;
            r_cj <= '0;
        end else if (i_cmd.pos_init) begin
            r_ci <= '0;
            r_cj <= '0;
        end else if (i_cmd.spl_step) begin
            if (r_cj == span) begin
                r_cj <= '0;
                r_ci <= r_ci + RAD_W'(1);
            end else begin
                r_cj <= r_cj + RAD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_init) begin
            r_cx <= wx;
            r_cy <= wy;
        end else if (i_cmd.spl_step) begin
            if (r_cj == span) begin
                r_cy <= wy;
                r_cx <= (r_cx == XW'(GRID_WIDTH - 1)) ? '0 : r_cx + XW'(1);
            end else begin
                r_cy <= (r_cy == YW'(GRID_HEIGHT - 1)) ? '0 : r_cy + YW'(1);
            end
        end
    end

    // Cell and kernel addresses
    always_comb begin
        addr_cur = GA_W'(r_cx) * GA_W'(GRID_HEIGHT) + GA_W'(r_cy);
        ki       = KA_W'(r_ci) + KA_W'(MAX_RADIUS) - KA_W'(rad);
        kj       = KA_W'(r_cj) + KA_W'(MAX_RADIUS) - KA_W'(rad);
        kaddr    = ki * KA_W'(KSIDE) + kj;
    end

    // Saturating accumulate of the fetched cell and kernel entry
    always_comb begin
        sum = {r_grd[VAL_W-1], r_grd} + {r_krd[VAL_W-1], r_krd};
        sat = sum[VAL_W-1:0];
        if (sum[VAL_W] != sum[VAL_W-1]) begin
            sat = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // Grid port select
    always_comb begin
        gwe    = i_cmd.sweep_step | i_cmd.grid_wr | i_cmd.spl_wr;
        gaddr  = i_cmd.sweep_step ? r_sweep : addr_cur;
        gwdata = r_value;
        if (i_cmd.sweep_step && i_cmd.sweep_zero) begin
            gwdata = '0;
        end else if (i_cmd.spl_wr) begin
            gwdata = sat;
        end
    end

    // Grid memory
    always_ff @(posedge i_clk) begin
        if (gwe) begin
            r_grid[gaddr] <= gwdata;
        end
        if (i_cmd.mem_rd) begin
            r_grd <= r_grid[gaddr];
        end
    end

    // Kernel memory; loads past the kernel size are dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.kload && (32'(r_kidx) < KDEPTH)) begin
            r_kern[KA_W'(r_kidx)] <= r_value;
        end
        if (i_cmd.mem_rd) begin
            r_krd <= r_kern[kaddr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out <= i_cmd.res_read ? r_grd : '0;
        end
    end

    assign o_m_axis_tdata       = r_out;
    assign o_status.in_func     = t_func'(i_s_axis_tuser);
    assign o_status.wrap_done   = done_x & done_y;
    assign o_status.sweep_last  = (r_sweep == GA_W'(GDEPTH - 1));
    assign o_status.spl_last    = (r_ci == span) && (r_cj == span);

endmodule

FILE: hdl/tks_ctrl.sv
// Controller: sequences each operation and owns the stream handshakes.
`timescale 1ns / 1ps

module tks_ctrl import tks_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    output logic    o_m_axis_tvalid,
    input  logic    i_m_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR     = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_KLOAD     = 11'b000_0000_0100,
        ST_FILL      = 11'b000_0000_1000,
        ST_WRAP_GO   = 11'b000_0001_0000,
        ST_WRAP_WAIT = 11'b000_0010_0000,
        ST_WR        = 11'b000_0100_0000,
        ST_RD        = 11'b000_1000_0000,
        ST_SPL_RD    = 11'b001_0000_0000,
        ST_SPL_WR    = 11'b010_0000_0000,
        ST_DONE      = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    t_func  r_func, n_func;
    logic   r_ovalid, n_ovalid;
    t_cmd   cmd;
    logic   ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_func   <= FN_KLOAD;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_func   <= n_func;
            r_ovalid <= n_ovalid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        cmd     = '0;
        ready   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_zero = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ready = 1'b1;
                if (i_s_axis_tvalid) begin
                    cmd.load_item = 1'b1;
                    n_func        = i_status.in_func;
                    case (i_status.in_func)
                        FN_KLOAD: n_state = ST_KLOAD;
                        FN_FILL:  n_state = ST_FILL;
                        FN_WRITE: n_state = ST_WRAP_GO;
                        FN_SPLAT: n_state = ST_WRAP_GO;
                        FN_READ:  n_state = ST_WRAP_GO;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_KLOAD: begin
                cmd.kload = 1'b1;
                n_state   = ST_DONE;
            end
            ST_FILL: begin
                cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_WRAP_GO: begin
                cmd.wrap_start = 1'b1;
                cmd.wrap_rad   = (r_func == FN_SPLAT);
                n_state        = ST_WRAP_WAIT;
            end
            ST_WRAP_WAIT: begin
                cmd.wrap_rad = (r_func == FN_SPLAT);
                if (i_status.wrap_done) begin
                    cmd.pos_init = 1'b1;
                    case (r_func)
                        FN_WRITE: n_state = ST_WR;
                        FN_READ:  n_state = ST_RD;
                        default:  n_state = ST_SPL_RD;
                    endcase
                end
            end
            ST_WR: begin
                cmd.grid_wr = 1'b1;
                n_state     = ST_DONE;
            end
            ST_RD: begin
                cmd.mem_rd = 1'b1;
                n_state    = ST_DONE;
            end
            ST_SPL_RD: begin
                cmd.mem_rd = 1'b1;
                n_state    = ST_SPL_WR;
            end
            ST_SPL_WR: begin
                cmd.spl_wr   = 1'b1;
                cmd.spl_step = 1'b1;
                n_state      = i_status.spl_last ? ST_DONE : ST_SPL_RD;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!r_ovalid || i_m_axis_tready) begin
                    cmd.res_load = 1'b1;
                    cmd.res_read = (r_func == FN_READ);
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output word valid flag
    always_comb begin
        n_ovalid = cmd.res_load | (r_ovalid & ~i_m_axis_tready);
    end

    assign o_cmd           = cmd;
    assign o_s_axis_tready = ready;
    assign o_m_axis_tvalid = r_ovalid;

endmodule

FILE: hdl/toroidal_kernel_splat.sv
// Top level of the toroidal kernel splat block: controller, datapath and checks.
//
//  channel   | dir | handshake                          | payload
//  ----------+-----+------------------------------------+-----------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready  | tuser func; tdata x,y,kidx,value
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready  | tdata cell_value
//  cfg       | in  | i_cfg_we                           | i_cfg_wdata kernel_radius
//
// Coordinate reduction is a reciprocal multiply, a multiply-subtract and one correcting
// subtract; a splat does one read and one write per kernel cell through the single grid
// port. After reset a clearing pass writes zero to all W*H grid words; no word is taken
// during it. The next word is taken while a result still waits on m_axis; a stalled
// m_axis holds the block only once the next result is ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module toroidal_kernel_splat import tks_pkg::*; #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int MAX_RADIUS  = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // coord_x [15:0], coord_y [31:16], kernel_index [39:32], value [71:40]
    input  logic [IN_W-1:0]     i_s_axis_tdata,
    // func [2:0]
    input  logic [FUNC_W-1:0]   i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // cell_value [31:0]
    output logic [OUT_W-1:0]    o_m_axis_tdata,
    input  logic                i_cfg_we,
    input  logic [RCFG_W-1:0]   i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    tks_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    tks_dpath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .MAX_RADIUS  (MAX_RADIUS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // One word at a time: the input closes right after a word is taken
    `ASSERT_NEXT(a_one_word, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready,
                 "input still open after a word was taken")

    // The remainder units are busy the cycle after a start
    `ASSERT_NEXT(a_wrap_busy, cmd.wrap_start, !status.wrap_done,
                 "coordinate reduction finished too early")

    // A loaded result is offered on the next cycle
    `ASSERT_NEXT(a_result_shown, cmd.res_load, o_m_axis_tvalid, "loaded result not offered")

    // Grid writes and reads never share a cycle on the single port
    `ASSERT_SAME(a_port_excl, cmd.mem_rd, !(cmd.grid_wr || cmd.spl_wr || cmd.sweep_step),
                 "grid read and write in the same cycle")

endmodule
